### hdl/ren_pkg.sv
// Types and constants shared by the election node modules.
`default_nettype none

package ren_pkg;

    localparam int unsigned TERM_W  = 32;
    localparam int unsigned NODE_W  = 8;
    localparam int unsigned AGE_W   = 16;
    localparam int unsigned VOTES_W = 8;

    localparam logic [TERM_W-1:0]  TERM_MAX  = '1;
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
    localparam logic [VOTES_W-1:0] VOTES_MAX = '1;
    localparam logic [NODE_W-1:0]  NODE_ALL  = '0;

    // Configuration register indexes
    localparam logic [1:0] CFG_NODE_ID   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [NODE_W-1:0]  NODE_ID_RST   = 8'd1;
    localparam logic [AGE_W-1:0]   TIMEOUT_RST   = 16'd300;
    localparam logic [VOTES_W-1:0] THRESHOLD_RST = 8'd2;

    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_VOTE_REQ  = 2'd1,
        FUNC_VOTE_RESP = 2'd2,
        FUNC_HEARTBEAT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_VOTE_REQ  = 2'd0,
        KIND_VOTE_RESP = 2'd1,
        KIND_HEARTBEAT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ROLE_NONE   = 3'd0,
        ROLE_FOLLOW = 3'd1,
        ROLE_LEADER = 3'd2,
        ROLE_CAND   = 3'd3,
        ROLE_VOTED  = 3'd4
    } t_role;

    typedef struct packed {
        t_func              func;
        logic [TERM_W-1:0]  term;
        logic [NODE_W-1:0]  node;
        logic               granted;
    } t_event;

    typedef struct packed {
        logic [NODE_W-1:0]  node_id;
        logic [AGE_W-1:0]   timeout;
        logic [VOTES_W-1:0] threshold;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [NODE_W-1:0]  dest;
        logic [TERM_W-1:0]  term;
        logic [NODE_W-1:0]  sender;
        logic               granted;
    } t_msg;

endpackage

`default_nettype wire

### hdl/ren_front.sv
// Front end: accepts events, unpacks them into event records and queues them for the back end.
`default_nettype none

module ren_front #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [47:0]      i_s_tdata,  // msg_term, msg_node, msg_granted, zero pad
    input  wire logic [1:0]       i_s_tuser,  // func
    output logic                  o_ev_valid,
    output ren_pkg::t_event       o_ev,
    input  wire logic             i_ev_pop
);
    import ren_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    t_event           w_ev_in;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_ev_in.func    = t_func'(i_s_tuser);
        w_ev_in.term    = i_s_tdata[31:0];
        w_ev_in.node    = i_s_tdata[39:32];
        w_ev_in.granted = i_s_tdata[40];
    end

    assign o_s_tready = (r_count != CNT_FULL);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_ev_valid = (r_count != '0);
    assign w_pop      = i_ev_pop && o_ev_valid;
    assign o_ev       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_ev_in;
        end
    end

endmodule

`default_nettype wire

### hdl/ren_back.sv
// Back end: election state machine and registered outgoing message.
`default_nettype none

module ren_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ren_pkg::t_cfg    i_cfg,
    input  wire logic             i_ev_valid,
    input  wire ren_pkg::t_event  i_ev,
    output logic                  o_ev_pop,
    output logic                  o_msg_valid,
    output ren_pkg::t_msg         o_msg,
    input  wire logic             i_msg_ready
);
    import ren_pkg::*;

    logic [TERM_W-1:0]  r_term,    n_term;
    t_role              r_role,    n_role;
    logic [NODE_W-1:0]  r_partner, n_partner;
    logic [VOTES_W-1:0] r_votes,   n_votes;
    logic [AGE_W-1:0]   r_age,     n_age;
    logic               r_out_valid;
    t_msg               r_out;

    logic               w_emit;
    t_kind              w_kind;
    logic [NODE_W-1:0]  w_dest;
    logic               w_grant;
    logic               w_term_gt;
    logic               w_term_eq;
    logic [AGE_W-1:0]   w_age_inc;
    logic [VOTES_W-1:0] w_votes_inc;

    // Take the next event whenever the output slot is free or being drained
    assign o_ev_pop    = i_ev_valid && (!r_out_valid || i_msg_ready);
    assign o_msg_valid = r_out_valid;
    assign o_msg       = r_out;

    assign w_term_gt   = (i_ev.term > r_term);
    assign w_term_eq   = (i_ev.term == r_term);
    assign w_age_inc   = (r_age != AGE_MAX) ? r_age + 1'b1 : r_age;
    assign w_votes_inc = (r_votes != VOTES_MAX) ? r_votes + 1'b1 : r_votes;

    always_comb begin
        n_term    = r_term;
        n_role    = r_role;
        n_partner = r_partner;
        n_votes   = r_votes;
        n_age     = r_age;
        w_emit    = 1'b0;
        w_kind    = KIND_VOTE_REQ;
        w_dest    = NODE_ALL;
        w_grant   = 1'b0;

        case (i_ev.func)
            FUNC_TICK: begin
                if (r_role == ROLE_FOLLOW) begin
                    n_age = w_age_inc;
                end
                if (r_role == ROLE_NONE ||
                    (r_role == ROLE_FOLLOW && w_age_inc > i_cfg.timeout)) begin
                    // Start an election
                    n_role  = ROLE_CAND;
                    n_votes = VOTES_W'(1);
                    if (r_term != TERM_MAX) begin
                        n_term = r_term + 1'b1;
                    end
                    w_emit = 1'b1;
                    w_kind = KIND_VOTE_REQ;
                end else if (r_role == ROLE_LEADER) begin
                    w_emit = 1'b1;
                    w_kind = KIND_HEARTBEAT;
                end
            end
            FUNC_VOTE_REQ: begin
                if (w_term_gt) begin
                    n_term  = i_ev.term;
                    w_grant = 1'b1;
                end else if (w_term_eq) begin
                    case (r_role)
                        ROLE_NONE, ROLE_FOLLOW: w_grant = 1'b1;
                        ROLE_LEADER, ROLE_CAND: w_grant = 1'b0;
                        default:                w_grant = (r_partner == i_ev.node);
                    endcase
                end
                if (w_grant) begin
                    n_role    = ROLE_VOTED;
                    n_partner = i_ev.node;
                    n_votes   = '0;
                end
                w_emit = 1'b1;
                w_kind = KIND_VOTE_RESP;
                w_dest = i_ev.node;
            end
            FUNC_VOTE_RESP: begin
                if (w_term_gt) begin
                    n_term  = i_ev.term;
                    n_role  = ROLE_NONE;
                    n_votes = '0;
                end else if (r_role == ROLE_CAND && i_ev.granted && w_term_eq) begin
                    n_votes = w_votes_inc;
                    if (w_votes_inc > i_cfg.threshold) begin
                        n_role = ROLE_LEADER;
                    end
                end
            end
            default: begin
                // Heartbeat from another node at an equal or newer term
                if (i_ev.node != i_cfg.node_id && (w_term_gt || w_term_eq)) begin
                    n_term    = i_ev.term;
                    n_role    = ROLE_FOLLOW;
                    n_partner = i_ev.node;
                    n_age     = '0;
                    n_votes   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term      <= '0;
            r_role      <= ROLE_NONE;
            r_partner   <= '0;
            r_votes     <= '0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ev_pop) begin
                r_term    <= n_term;
                r_role    <= n_role;
                r_partner <= n_partner;
                r_votes   <= n_votes;
                r_age     <= n_age;
            end
            if (o_ev_pop && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_msg_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_pop && w_emit) begin
            r_out.kind    <= w_kind;
            r_out.dest    <= w_dest;
            r_out.term    <= n_term;
            r_out.sender  <= i_cfg.node_id;
            r_out.granted <= w_grant;
        end
    end

endmodule

`default_nettype wire

### hdl/raft_election_node.sv
// Top level of the leader-election node: config registers, front end, back end.
//
// Input stream (i_s_*): one event per request; tuser carries the event kind,
// tdata the message term, sender id and vote outcome.
// Output stream (o_m_*): at most one message per event; tuser carries the
// message kind, tdata destination, term, sender id and vote outcome.
// Config channel (i_cfg_*): register index and data; always ready. Write only
// while no event is in flight.
// An event is queued when accepted; the back end processes it at the queue
// head and registers its message, shown on o_m_tvalid.
// Throughput: one event per cycle while the output is free or being drained.
// A stalled receiver holds the output register; the back end stops popping
// and the QUEUE_DEPTH-entry event queue keeps taking events until full.
// Reset clears the term, role, partner, vote count, heartbeat age and the
// queue, and restores node_id 1, timeout 300 ticks and threshold 2.
`default_nettype none

module raft_election_node #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // [31:0] msg_term, [39:32] msg_node, [40] msg_granted
    input  wire logic [1:0]  i_s_tuser,   // [1:0] func
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,   // [7:0] out_dest, [39:8] out_term,
                                          // [47:40] out_sender, [48] out_granted
    output logic [1:0]       o_m_tuser,   // [1:0] out_kind
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import ren_pkg::*;

    t_cfg   r_cfg;
    logic   w_ev_valid;
    t_event w_ev;
    logic   w_ev_pop;
    logic   w_msg_valid;
    t_msg   w_msg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id   <= NODE_ID_RST;
            r_cfg.timeout   <= TIMEOUT_RST;
            r_cfg.threshold <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NODE_ID:   r_cfg.node_id   <= i_cfg_data[NODE_W-1:0];
                CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_data[AGE_W-1:0];
                CFG_THRESHOLD: r_cfg.threshold <= i_cfg_data[VOTES_W-1:0];
                default: ;
            endcase
        end
    end

    ren_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_ev_valid (w_ev_valid),
        .o_ev       (w_ev),
        .i_ev_pop   (w_ev_pop)
    );

    ren_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ev_valid  (w_ev_valid),
        .i_ev        (w_ev),
        .o_ev_pop    (w_ev_pop),
        .o_msg_valid (w_msg_valid),
        .o_msg       (w_msg),
        .i_msg_ready (i_m_tready)
    );

    assign o_m_tvalid = w_msg_valid;
    assign o_m_tuser  = w_msg.kind;
    assign o_m_tdata  = {7'd0, w_msg.granted, w_msg.sender, w_msg.term, w_msg.dest};

endmodule

`default_nettype wire
